// File: hdl/bfgs_pkg.sv
package bfgs_pkg;

  localparam int DIM_DEF = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NENT = 9;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_IDENT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT,
    S_DIVST,
    S_DIVW,
    S_T,
    S_A,
    S_TM,
    S_NH,
    S_NHS,
    S_NHW,
    S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v, output logic ovf);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = 66'sd2147483647;
    mn = -66'sd2147483648;
    ovf = 1'b0;
    sat32 = v[31:0];
    if (v > mx) begin
      ovf = 1'b1;
      sat32 = 32'sh7fffffff;
    end else if (v < mn) begin
      ovf = 1'b1;
      sat32 = 32'sh80000000;
    end
  endfunction

endpackage

// File: hdl/bfgs_div.sv
module bfgs_div import bfgs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [65:0]  den,
  output logic                done,
  output logic signed [31:0]  quo,
  output logic                ovf
);
  localparam int NB = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] q;
  logic [65:0]   rem;
  logic [65:0]   dv;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          run;
  logic [65:0]   trial;
  logic signed [65:0] qs;

  // numerator is 2^(2F): its only set bit enters on the first step
  assign trial = {rem[64:0], (cnt == CW'(NB))};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NB);
        rem <= '0;
        q <= '0;
        neg <= den[65];
        dv <= den[65] ? 66'(-den) : den;
      end else if (run) begin
        if (trial >= dv) begin
          rem <= trial - dv;
          q <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qs = neg ? -$signed(66'(q)) : $signed(66'(q));
    quo = sat32(qs, ovf);
  end
endmodule

// File: hdl/bfgs_mac.sv
module bfgs_mac import bfgs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                clr,
  input  logic                en,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output logic signed [65:0]  acc
);
  logic signed [63:0] prod;
  logic signed [65:0] sh;

  assign prod = 64'(a) * 64'(b);
  assign sh = 66'(prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= en ? sh : '0;
    end else if (en) begin
      acc <= acc + sh;
    end
  end
endmodule

// File: hdl/bfgs_inverse_hessian_update_top.sv
// BFGS inverse-Hessian update, 3x3, Q16.16.
// Input channel: in_valid/in_stall with cmd, grad_diff_0..2 (y), step_0..2 (s).
// Output channel: out_valid/out_stall with m00..m22 and skipped.
// cmd=1 loads the identity; cmd=0 applies
//   H = (I - rho s y^T) H (I - rho y s^T) + rho s s^T, rho = 1/(y.s).
// Every transaction returns one result with the matrix after it.
// Arithmetic runs on one shared 32x32 multiply-accumulate unit plus a
// radix-2 restoring divider for rho (2*FRAC_BITS+1 steps).
// An update steps through dot, check, divide, t, A, A*H, new H and
// output; zero y.s goes from the check straight to output, and a reset
// command goes straight to output.
// in_stall is high while busy; the next transaction is accepted in the cycle
// after the result is loaded, so an update ends before the next one starts.
// A finished result is held in the output registers until taken; a result
// that is ready while the previous one is still stalled waits in the block.
// Zero y.s or any saturation sets skipped.
// Reset (rst, synchronous) restores the identity and empties the output.
module bfgs_inverse_hessian_update_top import bfgs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] grad_diff_0,
  input  logic signed [31:0] grad_diff_1,
  input  logic signed [31:0] grad_diff_2,
  input  logic signed [31:0] step_0,
  input  logic signed [31:0] step_1,
  input  logic signed [31:0] step_2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] m20,
  output logic signed [31:0] m21,
  output logic signed [31:0] m22,
  output logic               skipped
);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  state_t state, state_next;
  logic signed [31:0] h  [NENT];
  logic signed [31:0] am [NENT];
  logic signed [31:0] tm [NENT];
  logic signed [31:0] yv [3];
  logic signed [31:0] sv [3];
  logic signed [31:0] tv [3];
  logic signed [31:0] rho;
  logic               satf;
  logic               skipr;
  logic [1:0]         i, j, k;
  logic               wb;
  logic [3:0]         ij, ik, kj, jk;

  logic               mclr, men;
  logic signed [31:0] ma, mb;
  logic signed [65:0] acc;
  logic signed [31:0] accs;
  logic               accovf;
  logic signed [65:0] asub_w;
  logic signed [31:0] asub;
  logic               asubovf;
  logic signed [65:0] nsum;
  logic signed [65:0] nh_w;
  logic signed [31:0] nhv;
  logic               nhovf;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] dquo;
  logic               dovf;
  logic               out_load;

  bfgs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .clr(mclr), .en(men), .a(ma), .b(mb), .acc(acc)
  );

  bfgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .den(acc),
    .done(div_done), .quo(dquo), .ovf(dovf)
  );

  assign in_stall = (state != S_IDLE);
  assign div_start = (state == S_DIVST) && (acc != 66'sd0);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign ij = {2'b00, i} * 4'd3 + {2'b00, j};
  assign ik = {2'b00, i} * 4'd3 + {2'b00, k};
  assign kj = {2'b00, k} * 4'd3 + {2'b00, j};
  assign jk = {2'b00, j} * 4'd3 + {2'b00, k};

  always_comb begin
    accs = sat32(acc, accovf);
    asub_w = (i == j ? 66'(ONE) : 66'sd0) - 66'(accs);
    asub = sat32(asub_w, asubovf);
    nh_w = nsum + 66'(accs);
    nhv = sat32(nh_w, nhovf);
  end

  // operand select: k steps the inner products, wb cycles only write back
  always_comb begin
    ma = '0;
    mb = '0;
    men = 1'b0;
    mclr = 1'b0;
    unique case (state)
      S_DOT: begin
        ma = yv[k]; mb = sv[k]; men = 1'b1; mclr = (k == 2'd0);
      end
      S_T: begin
        ma = rho; mb = sv[i]; men = !wb; mclr = 1'b1;
      end
      S_A: begin
        ma = tv[i]; mb = yv[j]; men = !wb; mclr = 1'b1;
      end
      S_TM: begin
        ma = am[ik]; mb = h[kj]; men = !wb; mclr = (k == 2'd0);
      end
      S_NH: begin
        ma = tm[ik]; mb = am[jk]; men = 1'b1; mclr = (k == 2'd0);
      end
      S_NHS: begin
        ma = tv[i]; mb = sv[j]; men = 1'b1; mclr = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = (cmd == CMD_IDENT) ? S_OUT : S_DOT;
      S_DOT: if (k == 2'd2) state_next = S_DIVST;
      S_DIVST: state_next = (acc == 66'sd0) ? S_OUT : S_DIVW;
      S_DIVW: if (div_done) state_next = S_T;
      S_T: if (wb && i == 2'd2) state_next = S_A;
      S_A: if (wb && i == 2'd2 && j == 2'd2) state_next = S_TM;
      S_TM: if (wb && i == 2'd2 && j == 2'd2) state_next = S_NH;
      S_NH: if (k == 2'd2) state_next = S_NHS;
      S_NHS: state_next = S_NHW;
      S_NHW: state_next = (i == 2'd2 && j == 2'd2) ? S_OUT : S_NH;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NENT; n++) h[n] <= (n == 0 || n == 4 || n == 8) ? ONE : '0;
      i <= '0; j <= '0; k <= '0; wb <= 1'b0;
      satf <= 1'b0; skipr <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            yv[0] <= grad_diff_0; yv[1] <= grad_diff_1; yv[2] <= grad_diff_2;
            sv[0] <= step_0; sv[1] <= step_1; sv[2] <= step_2;
            i <= '0; j <= '0; k <= '0; wb <= 1'b0;
            satf <= 1'b0; skipr <= 1'b0;
            if (cmd == CMD_IDENT) begin
              for (int n = 0; n < NENT; n++) h[n] <= (n == 0 || n == 4 || n == 8) ? ONE : '0;
            end
          end
        end
        S_DOT: k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        S_DIVST: begin
          if (acc == 66'sd0) skipr <= 1'b1;
        end
        S_DIVW: begin
          if (div_done) begin
            rho <= dquo;
            satf <= satf | dovf;
          end
        end
        S_T: begin
          wb <= !wb;
          if (wb) begin
            tv[i] <= accs; satf <= satf | accovf;
            i <= (i == 2'd2) ? 2'd0 : i + 2'd1;
          end
        end
        S_A: begin
          wb <= !wb;
          if (wb) begin
            am[ij] <= asub; satf <= satf | accovf | asubovf;
            if (j == 2'd2) begin
              j <= '0; i <= (i == 2'd2) ? 2'd0 : i + 2'd1;
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        S_TM: begin
          if (!wb) begin
            k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
            wb <= (k == 2'd2);
          end else begin
            wb <= 1'b0;
            tm[ij] <= accs; satf <= satf | accovf;
            if (j == 2'd2) begin
              j <= '0; i <= (i == 2'd2) ? 2'd0 : i + 2'd1;
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        S_NH: k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        S_NHS: nsum <= acc;
        S_NHW: begin
          // acc holds t_i*s_j, saturated on its own before the sum
          h[ij] <= nhv; satf <= satf | accovf | nhovf;
          if (j == 2'd2) begin
            j <= '0; i <= (i == 2'd2) ? 2'd0 : i + 2'd1;
          end else begin
            j <= j + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && out_load) begin
      skipped <= skipr | satf;
      m00 <= h[0]; m01 <= h[1]; m02 <= h[2];
      m10 <= h[3]; m11 <= h[4]; m12 <= h[5];
      m20 <= h[6]; m21 <= h[7]; m22 <= h[8];
    end
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(m00) && out_valid) else $error("out changed");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW)) else $error("stray div done");
`endif
endmodule
